[rtl/vfcm_pkg.sv]
// ----------------------------------------------------------------------------
// vfcm_pkg: shared types and constants of the voxel face culling mesher
// Holds the stored voxel word, the face direction codes and the sequencer
// state encoding.
// ----------------------------------------------------------------------------
package vfcm_pkg;

    // Fixed field widths of the item and result payloads.
    localparam int TEX_W          = 8;
    localparam int TEX_RANGE      = 1 << TEX_W;
    localparam int MATERIAL_COUNT = 4;
    // Width used for coordinate range compares (holds heights up to 256).
    localparam int CMP_W          = 9;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MESH  = 1'b1;

    // One stored cell: the tile index is kept already split into row and column.
    typedef struct packed {
        logic       solid;
        logic [1:0] material;
        logic [1:0] row;
        logic [1:0] col;
    } voxel_t;

    // Face directions in emission order; the last code addresses the cell itself.
    typedef enum logic [2:0] {
        DIR_POS_Z,
        DIR_NEG_Z,
        DIR_POS_X,
        DIR_NEG_X,
        DIR_POS_Y,
        DIR_NEG_Y,
        DIR_SELF
    } dir_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_WRITE,
        ST_READ,
        ST_LAST,
        ST_EVAL,
        ST_EMIT
    } state_t;

endpackage

[rtl/voxel_face_cull_mesher.sv]
// ----------------------------------------------------------------------------
// voxel_face_cull_mesher: voxel store with face culling
// An in-range write transaction passes the CALC and WRITE states before ready returns.
// A mesh transaction reads 7 store entries through one address unit; its first
// face, if any, is loaded in EVAL after the reads, then one face per cycle as taken.
// After reset the store is cleared one entry a cycle (all AXIS_LEN^2*HEIGHT_LEN
// entries, 16384 by default) before the first transaction is accepted.
// ----------------------------------------------------------------------------
module voxel_face_cull_mesher #(
    parameter int AXIS_LEN        = 16,
    parameter int HEIGHT_LEN      = 64,
    parameter int ATLAS_ROW_TILES = 4,
    parameter int ATLAS_COL_TILES = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [3:0] s_pos_x,
    input  logic [5:0] s_pos_y,
    input  logic [3:0] s_pos_z,
    input  logic       s_solid_in,
    input  logic [2:0] s_material_in,
    input  logic [7:0] s_texture_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_face_x,
    output logic [5:0] m_face_y,
    output logic [3:0] m_face_z,
    output logic [2:0] m_face_dir,
    output logic [1:0] m_face_material,
    output logic [1:0] m_tile_col,
    output logic [1:0] m_tile_row,
    output logic       m_last_face
);

    localparam int AREA       = AXIS_LEN * AXIS_LEN;
    localparam int DEPTH      = AREA * HEIGHT_LEN;
    localparam int AW         = $clog2(DEPTH);
    localparam int TILE_COUNT = ATLAS_ROW_TILES * ATLAS_COL_TILES;
    localparam int MAP_W      = 4 * vfcm_pkg::TEX_RANGE;

    // Texture index to {row, col} map, built at elaboration by counting.
    function automatic logic [MAP_W-1:0] build_tile_map();
        logic [MAP_W-1:0] map;
        int               row;
        int               col;
        map = '0;
        row = 0;
        col = 0;
        for (int i = 0; i < vfcm_pkg::TEX_RANGE; i++) begin
            if (i < TILE_COUNT) begin
                map[i*4 +: 4] = {2'(row), 2'(col)};
            end
            col++;
            if (col == ATLAS_ROW_TILES) begin
                col = 0;
                row++;
            end
        end
        return map;
    endfunction

    localparam logic [MAP_W-1:0] TILE_MAP = build_tile_map();

    vfcm_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             vld_d_reg;
    vfcm_pkg::dir_t   step_reg, step_next;
    vfcm_pkg::dir_t   step_d_reg;
    logic             out_d_reg;
    logic [5:0]       mask_reg, mask_next;

    logic             cmd_reg;
    logic [3:0]       x_reg;
    logic [5:0]       y_reg;
    logic [3:0]       z_reg;
    vfcm_pkg::voxel_t wdata_reg;
    logic [AW-1:0]    base_reg;
    vfcm_pkg::voxel_t self_reg;

    logic [3:0]       face_x_reg;
    logic [5:0]       face_y_reg;
    logic [3:0]       face_z_reg;
    logic [2:0]       face_dir_reg;
    logic [1:0]       face_mat_reg;
    logic [1:0]       tile_col_reg;
    logic [1:0]       tile_row_reg;
    logic             last_reg;

    logic             accept;
    logic             in_range;
    logic [AW-1:0]    base_calc;
    logic [AW-1:0]    nbr_addr;
    logic             nbr_out;
    vfcm_pkg::voxel_t rd_data;
    vfcm_pkg::voxel_t wr_data;
    logic [AW-1:0]    wr_addr;
    logic             wr_en;
    logic             rd_en;
    logic [2:0]       pick_dir;
    logic [5:0]       rest_mask;
    logic             pick_last;
    logic             out_free;
    logic             load;
    vfcm_pkg::voxel_t wdata_in;
    logic [3:0]       tile_entry;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == vfcm_pkg::ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Sanitize a write at acceptance: unknown material and tile map to zero.
    assign tile_entry = TILE_MAP[{s_texture_in, 2'b00} +: 4];
    always_comb begin
        wdata_in.solid    = s_solid_in;
        wdata_in.material = (s_material_in < 3'(vfcm_pkg::MATERIAL_COUNT))
                            ? s_material_in[1:0] : 2'b00;
        wdata_in.row      = tile_entry[3:2];
        wdata_in.col      = tile_entry[1:0];
    end

    // Cell address and chunk range check from the captured coordinates.
    assign in_range  = ({5'b0, x_reg} < vfcm_pkg::CMP_W'(AXIS_LEN))
                    && ({5'b0, z_reg} < vfcm_pkg::CMP_W'(AXIS_LEN))
                    && ({3'b0, y_reg} < vfcm_pkg::CMP_W'(HEIGHT_LEN));
    assign base_calc = AW'(AW'(y_reg) * AW'(AREA))
                     + AW'(AW'(z_reg) * AW'(AXIS_LEN))
                     + AW'(x_reg);

    // Shared neighbor address unit.
    vfcm_addr_unit #(
        .AXIS_LEN  (AXIS_LEN),
        .HEIGHT_LEN(HEIGHT_LEN),
        .AW        (AW)
    ) u_addr_unit (
        .pos_x  (x_reg),
        .pos_y  (y_reg),
        .pos_z  (z_reg),
        .base   (base_reg),
        .dir    (step_reg),
        .addr   (nbr_addr),
        .outside(nbr_out)
    );

    // Store write port: clearing sweep after reset, else the write transaction.
    assign wr_en   = (state_reg == vfcm_pkg::ST_CLEAR) || (state_reg == vfcm_pkg::ST_WRITE);
    assign wr_addr = (state_reg == vfcm_pkg::ST_CLEAR) ? clr_cnt_reg : base_reg;
    assign wr_data = (state_reg == vfcm_pkg::ST_CLEAR) ? '0 : wdata_reg;
    assign rd_en   = (state_reg == vfcm_pkg::ST_READ);

    vfcm_store #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(nbr_addr),
        .rd_data(rd_data)
    );

    // Lowest open side goes next; it is the last one when no other side remains.
    always_comb begin
        pick_dir = '0;
        for (int i = 5; i >= 0; i--) begin
            if (mask_reg[i]) begin
                pick_dir = 3'(i);
            end
        end
    end
    assign rest_mask = mask_reg & ~(6'b000001 << pick_dir);
    assign pick_last = (rest_mask == '0);

    // Sequencer: next state and control.
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        step_next    = step_reg;
        load         = 1'b0;
        case (state_reg)
            vfcm_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = vfcm_pkg::ST_IDLE;
                end
            end
            vfcm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = vfcm_pkg::ST_CALC;
                end
            end
            vfcm_pkg::ST_CALC: begin
                step_next = vfcm_pkg::DIR_POS_Z;
                if (!in_range) begin
                    state_next = vfcm_pkg::ST_IDLE;
                end else if (cmd_reg == vfcm_pkg::CMD_WRITE) begin
                    state_next = vfcm_pkg::ST_WRITE;
                end else begin
                    state_next = vfcm_pkg::ST_READ;
                end
            end
            vfcm_pkg::ST_WRITE: begin
                state_next = vfcm_pkg::ST_IDLE;
            end
            vfcm_pkg::ST_READ: begin
                if (step_reg == vfcm_pkg::DIR_SELF) begin
                    state_next = vfcm_pkg::ST_LAST;
                end else begin
                    step_next = vfcm_pkg::dir_t'(step_reg + 3'd1);
                end
            end
            vfcm_pkg::ST_LAST: begin
                state_next = vfcm_pkg::ST_EVAL;
            end
            vfcm_pkg::ST_EVAL: begin
                if (!self_reg.solid || (mask_reg == '0)) begin
                    state_next = vfcm_pkg::ST_IDLE;
                end else if (out_free) begin
                    load       = 1'b1;
                    state_next = pick_last ? vfcm_pkg::ST_IDLE : vfcm_pkg::ST_EMIT;
                end
            end
            vfcm_pkg::ST_EMIT: begin
                if (out_free) begin
                    load       = 1'b1;
                    state_next = pick_last ? vfcm_pkg::ST_IDLE : vfcm_pkg::ST_EMIT;
                end
            end
            default: begin
                state_next = vfcm_pkg::ST_IDLE;
            end
        endcase
    end

    // Open side mask: cleared per item, filled as read data returns, drained on emit.
    always_comb begin
        mask_next = mask_reg;
        if (state_reg == vfcm_pkg::ST_CALC) begin
            mask_next = '0;
        end
        if (vld_d_reg && (step_d_reg != vfcm_pkg::DIR_SELF)) begin
            mask_next[step_d_reg] = out_d_reg || !rd_data.solid;
        end
        if (load) begin
            mask_next = rest_mask;
        end
    end

    // Output valid holds until the face is taken or replaced.
    assign m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= vfcm_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            vld_d_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            vld_d_reg   <= rd_en;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        step_d_reg <= step_reg;
        out_d_reg  <= nbr_out;
        mask_reg   <= mask_next;
        if (accept) begin
            cmd_reg   <= s_cmd;
            x_reg     <= s_pos_x;
            y_reg     <= s_pos_y;
            z_reg     <= s_pos_z;
            wdata_reg <= wdata_in;
        end
        if (state_reg == vfcm_pkg::ST_CALC) begin
            base_reg <= base_calc;
        end
        if (vld_d_reg && (step_d_reg == vfcm_pkg::DIR_SELF)) begin
            self_reg <= rd_data;
        end
        if (load) begin
            face_x_reg   <= x_reg;
            face_y_reg   <= y_reg;
            face_z_reg   <= z_reg;
            face_dir_reg <= pick_dir;
            face_mat_reg <= self_reg.material;
            tile_col_reg <= self_reg.col;
            tile_row_reg <= self_reg.row;
            last_reg     <= pick_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_face_x        = face_x_reg;
    assign m_face_y        = face_y_reg;
    assign m_face_z        = face_z_reg;
    assign m_face_dir      = face_dir_reg;
    assign m_face_material = face_mat_reg;
    assign m_tile_col      = tile_col_reg;
    assign m_tile_row      = tile_row_reg;
    assign m_last_face     = last_reg;

endmodule

[rtl/vfcm_addr_unit.sv]
// ----------------------------------------------------------------------------
// vfcm_addr_unit: shared neighbor address unit
// Forms the store address of one neighbor (or the cell itself) with a single
// add/subtract, and flags a neighbor that lies outside the chunk.
// ----------------------------------------------------------------------------
module vfcm_addr_unit #(
    parameter int AXIS_LEN   = 16,
    parameter int HEIGHT_LEN = 64,
    parameter int AW         = 14
) (
    input  logic [3:0]          pos_x,
    input  logic [5:0]          pos_y,
    input  logic [3:0]          pos_z,
    input  logic [AW-1:0]       base,
    input  vfcm_pkg::dir_t      dir,
    output logic [AW-1:0]       addr,
    output logic                outside
);

    localparam int AREA = AXIS_LEN * AXIS_LEN;

    logic [vfcm_pkg::CMP_W-1:0] coord;
    logic [vfcm_pkg::CMP_W-1:0] limit;
    logic [vfcm_pkg::CMP_W:0]   coord_inc;
    logic                       step_up;
    logic                       is_self;
    logic                       sub;
    logic [AW-1:0]              offset;
    logic [AW-1:0]              offset_eff;

    // Select the axis, its bound and the address stride for the direction.
    always_comb begin
        coord   = '0;
        limit   = vfcm_pkg::CMP_W'(AXIS_LEN);
        step_up = 1'b0;
        is_self = 1'b0;
        sub     = 1'b0;
        offset  = '0;
        case (dir)
            vfcm_pkg::DIR_POS_Z: begin
                coord   = vfcm_pkg::CMP_W'(pos_z);
                step_up = 1'b1;
                offset  = AW'(AXIS_LEN);
            end
            vfcm_pkg::DIR_NEG_Z: begin
                coord  = vfcm_pkg::CMP_W'(pos_z);
                sub    = 1'b1;
                offset = AW'(AXIS_LEN);
            end
            vfcm_pkg::DIR_POS_X: begin
                coord   = vfcm_pkg::CMP_W'(pos_x);
                step_up = 1'b1;
                offset  = AW'(1);
            end
            vfcm_pkg::DIR_NEG_X: begin
                coord  = vfcm_pkg::CMP_W'(pos_x);
                sub    = 1'b1;
                offset = AW'(1);
            end
            vfcm_pkg::DIR_POS_Y: begin
                coord   = vfcm_pkg::CMP_W'(pos_y);
                limit   = vfcm_pkg::CMP_W'(HEIGHT_LEN);
                step_up = 1'b1;
                offset  = AW'(AREA);
            end
            vfcm_pkg::DIR_NEG_Y: begin
                coord  = vfcm_pkg::CMP_W'(pos_y);
                limit  = vfcm_pkg::CMP_W'(HEIGHT_LEN);
                sub    = 1'b1;
                offset = AW'(AREA);
            end
            default: begin
                is_self = 1'b1;
            end
        endcase
    end

    // One compare against the chunk edge.
    assign coord_inc = {1'b0, coord} + {{vfcm_pkg::CMP_W{1'b0}}, 1'b1};
    assign outside   = !is_self && (step_up ? (coord_inc >= {1'b0, limit})
                                            : (coord == '0));

    // One adder serves both step directions: subtraction as add of the complement.
    assign offset_eff = offset ^ {AW{sub}};
    assign addr       = base + offset_eff + AW'(sub);

endmodule

[rtl/vfcm_store.sv]
// ----------------------------------------------------------------------------
// vfcm_store: voxel store
// One entry per cell, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module vfcm_store #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  vfcm_pkg::voxel_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output vfcm_pkg::voxel_t rd_data
);

    vfcm_pkg::voxel_t mem_reg [DEPTH];
    vfcm_pkg::voxel_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port with registered output.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/vfcm_checker.sv]
// ----------------------------------------------------------------------------
// vfcm_checker: port level checks of the voxel face culling mesher
// Watches the item and face channels and is bound to the top level.
// ----------------------------------------------------------------------------
module vfcm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_face_dir,
    input logic       m_last_face
);

    // A stalled face keeps its direction and last marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_face_dir) && $stable(m_last_face))
        else $error("stalled face transaction changed");

    // Only one item is in work: ready drops right after a transaction is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after an input transaction");

    // Faces of one cell follow back to back in rising direction order.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_face |=>
            m_valid && (m_face_dir > $past(m_face_dir)))
        else $error("face sequence broken before the last face");

    // Direction codes stay within the six sides.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_face_dir <= 3'(vfcm_pkg::DIR_NEG_Y))
        else $error("face direction out of range");

endmodule

bind voxel_face_cull_mesher vfcm_checker u_vfcm_checker (.*);
